FILE: rtl/slstk_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// slstk_pkg
// Shared types and constants for the searchable LIFO stack.
// ---------------------------------------------------------------------------
package slstk_pkg;

  // Number of stack entries (1 to 256)
  localparam int unsigned DEPTH   = 8;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned POS_W   = 8;
  localparam int unsigned COUNT_W = 9;
  // Fill counter holds 0..DEPTH
  localparam int unsigned FILL_W  = $clog2(DEPTH + 1);
  // Cell index width, at least one bit
  localparam int unsigned IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  typedef enum logic [1:0] {
    OP_PUSH   = 2'd0,
    OP_POP    = 2'd1,
    OP_SEARCH = 2'd2,
    OP_READ   = 2'd3
  } op_kind_t;

  // Per-cycle command broadcast along the cell chain
  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctrl_t;

  // One result transfer
  typedef struct packed {
    logic                      ok;
    logic signed [DATA_W-1:0]  read_value;
    logic [POS_W-1:0]          found_position;
    logic [COUNT_W-1:0]        count;
  } res_t;

endpackage : slstk_pkg
`default_nettype wire

FILE: rtl/slstk_cell.sv
`default_nettype none
// ---------------------------------------------------------------------------
// slstk_cell
// One stack slot: loads from the shallower neighbour on push, from the
// deeper neighbour on pop, and compares its entry with the search key.
// ---------------------------------------------------------------------------
module slstk_cell (
  input  wire logic                               clk,
  input  wire slstk_pkg::cell_ctrl_t              ctrl,
  input  wire logic signed [slstk_pkg::DATA_W-1:0] push_data,
  input  wire logic signed [slstk_pkg::DATA_W-1:0] pop_data,
  input  wire logic signed [slstk_pkg::DATA_W-1:0] key,
  output logic signed [slstk_pkg::DATA_W-1:0]      entry,
  output logic                                    match
);
  import slstk_pkg::*;

  logic signed [DATA_W-1:0] entry_r;

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      entry_r <= push_data;
    end else if (ctrl.pop) begin
      entry_r <= pop_data;
    end
  end

  assign entry = entry_r;
  assign match = (entry_r == key);

endmodule : slstk_cell
`default_nettype wire

FILE: rtl/slstk_out_buf.sv
`default_nettype none
// ---------------------------------------------------------------------------
// slstk_out_buf
// Two-slot result queue so a new item is taken while a result waits.
// ---------------------------------------------------------------------------
module slstk_out_buf (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             wr_en,
  input  wire slstk_pkg::res_t  wr_data,
  output logic                  wr_ready,
  output logic                  rd_valid,
  input  wire logic             rd_ready,
  output slstk_pkg::res_t       rd_data
);
  import slstk_pkg::*;

  res_t       head_r, head_nxt;
  res_t       tail_r, tail_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       rd_en;

  assign rd_valid = (cnt_r != 2'd0);
  assign wr_ready = (cnt_r != 2'd2);
  assign rd_data  = head_r;
  assign rd_en    = rd_valid && rd_ready;

  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    cnt_nxt  = cnt_r;
    if (rd_en && wr_en) begin
      if (cnt_r == 2'd1) begin
        head_nxt = wr_data;
      end else begin
        head_nxt = tail_r;
        tail_nxt = wr_data;
      end
    end else if (rd_en) begin
      head_nxt = tail_r;
      cnt_nxt  = cnt_r - 2'd1;
    end else if (wr_en) begin
      if (cnt_r == 2'd0) begin
        head_nxt = wr_data;
      end else begin
        tail_nxt = wr_data;
      end
      cnt_nxt = cnt_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    tail_r <= tail_nxt;
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule : slstk_out_buf
`default_nettype wire

FILE: rtl/searchable_lifo_stack_top.sv
`default_nettype none
// ---------------------------------------------------------------------------
// searchable_lifo_stack_top
// Bounded LIFO stack, top at position 0, with push, pop, search and read.
// ---------------------------------------------------------------------------
//  Channel  Dir  Handshake            Payload
//  in_      in   in_valid / in_ready  in_kind, in_value, in_position
//  out_     out  out_valid/out_ready  out_ok, out_read_value,
//                                     out_found_position, out_count
//
//  One item per clock: each transfer on in_ is executed in the cycle it is
//  accepted, the cell chain shifting or comparing all slots in parallel.
//  Its result is registered in the result queue and leaves on out_ after any older results.
//  A two-slot result queue keeps in_ready high while one result waits;
//  in_ready drops only when both slots hold untaken results.
//  Reset (rst_n low, synchronous) empties the stack and the result queue.
// ---------------------------------------------------------------------------
module searchable_lifo_stack_top (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [1:0]                          in_kind,
  input  wire logic signed [slstk_pkg::DATA_W-1:0] in_value,
  input  wire logic [slstk_pkg::POS_W-1:0]         in_position,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output logic                                     out_ok,
  output logic signed [slstk_pkg::DATA_W-1:0]      out_read_value,
  output logic [slstk_pkg::POS_W-1:0]              out_found_position,
  output logic [slstk_pkg::COUNT_W-1:0]            out_count
);
  import slstk_pkg::*;

  logic                     accept;
  op_kind_t                 kind;
  logic [FILL_W-1:0]        fill_r, fill_nxt;
  cell_ctrl_t               ctrl;
  logic signed [DATA_W-1:0] cell_q [DEPTH];
  logic [DEPTH-1:0]         cell_match;
  logic                     hit;
  logic [IDX_W-1:0]         hit_idx;
  logic                     pos_ok;
  res_t                     res;
  res_t                     head;

  assign accept = in_valid && in_ready;
  assign kind   = op_kind_t'(in_kind);

  // Push refused when full, pop refused when empty
  always_comb begin
    ctrl     = '0;
    fill_nxt = fill_r;
    if (accept) begin
      case (kind)
        OP_PUSH: begin
          if (fill_r < FILL_W'(DEPTH)) begin
            ctrl.push = 1'b1;
            fill_nxt  = fill_r + 1'b1;
          end
        end
        OP_POP: begin
          if (fill_r != '0) begin
            ctrl.pop = 1'b1;
            fill_nxt = fill_r - 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Cell chain: cell 0 takes the pushed value, the deepest cell refills with 0
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic signed [DATA_W-1:0] from_up;
    logic signed [DATA_W-1:0] from_down;
    if (g == 0) begin : g_first
      assign from_up = in_value;
    end else begin : g_mid
      assign from_up = cell_q[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign from_down = '0;
    end else begin : g_inner
      assign from_down = cell_q[g+1];
    end
    slstk_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .push_data (from_up),
      .pop_data  (from_down),
      .key       (in_value),
      .entry     (cell_q[g]),
      .match     (cell_match[g])
    );
  end

  // Shallowest occupied cell that matches wins
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (cell_match[i] && (FILL_W'(i) < fill_r)) begin
        hit     = 1'b1;
        hit_idx = IDX_W'(i);
      end
    end
  end

  assign pos_ok = (COUNT_W'(in_position) < COUNT_W'(fill_r));

  always_comb begin
    res       = '0;
    res.count = COUNT_W'(fill_nxt);
    case (kind)
      OP_PUSH:   res.ok = ctrl.push;
      OP_POP:    res.ok = ctrl.pop;
      OP_SEARCH: begin
        res.ok             = hit;
        res.found_position = POS_W'(hit_idx);
      end
      OP_READ: begin
        res.ok = pos_ok;
        if (pos_ok) begin
          res.read_value = cell_q[in_position[IDX_W-1:0]];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else begin
      fill_r <= fill_nxt;
    end
  end

  slstk_out_buf u_out_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (accept),
    .wr_data  (res),
    .wr_ready (in_ready),
    .rd_valid (out_valid),
    .rd_ready (out_ready),
    .rd_data  (head)
  );

  assign out_ok             = head.ok;
  assign out_read_value     = head.read_value;
  assign out_found_position = head.found_position;
  assign out_count          = head.count;

  // Fill never exceeds the number of cells
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(DEPTH))
    else $error("fill exceeds depth");

  // An accepted push with room grows the stack by one
  a_push_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && kind == OP_PUSH && fill_r < FILL_W'(DEPTH))
      |=> fill_r == $past(fill_r) + 1'b1)
    else $error("push did not grow fill");

  // Fill changes only on an accepted push or pop
  a_fill_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!accept || kind == OP_SEARCH || kind == OP_READ) |=> $stable(fill_r))
    else $error("fill changed without push or pop");

  // Input stalls only while results are waiting
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input stalled with no pending result");

endmodule : searchable_lifo_stack_top
`default_nettype wire

FILE: sim/slstk_result_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// slstk_result_checker
// Watches both channels of the searchable LIFO stack. It keeps its own copy
// of the stack, works out the result of every input transfer, and compares
// each output transfer with the oldest outstanding result, field by field.
// ---------------------------------------------------------------------------
module slstk_result_checker (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  input  wire logic                                in_ready,
  input  wire logic [1:0]                          in_kind,
  input  wire logic signed [slstk_pkg::DATA_W-1:0] in_value,
  input  wire logic [slstk_pkg::POS_W-1:0]         in_position,
  input  wire logic                                out_valid,
  input  wire logic                                out_ready,
  input  wire logic                                out_ok,
  input  wire logic signed [slstk_pkg::DATA_W-1:0] out_read_value,
  input  wire logic [slstk_pkg::POS_W-1:0]         out_found_position,
  input  wire logic [slstk_pkg::COUNT_W-1:0]       out_count,
  output int                                       fail_count,
  output int                                       results_seen
);
  import slstk_pkg::*;

  logic signed [DATA_W-1:0] shadow_stack [DEPTH];
  int unsigned              shadow_fill;
  res_t                     pending_results [$];
  res_t                     oldest;
  int                       fails = 0;
  int                       seen  = 0;

  // Applies one operation to the shadow stack and returns its result.
  function automatic res_t apply_stack_op(op_kind_t kind, logic signed [DATA_W-1:0] value,
                                          logic [POS_W-1:0] pos);
    res_t r;
    bit   hit;
    r   = '0;
    hit = 1'b0;
    case (kind)
      OP_PUSH: begin
        if (shadow_fill < DEPTH) begin
          for (int i = DEPTH - 1; i > 0; i--) shadow_stack[i] = shadow_stack[i-1];
          shadow_stack[0] = value;
          shadow_fill++;
          r.ok = 1'b1;
        end
      end
      OP_POP: begin
        if (shadow_fill > 0) begin
          for (int i = 0; i + 1 < DEPTH; i++) shadow_stack[i] = shadow_stack[i+1];
          shadow_stack[DEPTH-1] = '0;
          shadow_fill--;
          r.ok = 1'b1;
        end
      end
      OP_SEARCH: begin
        // every held entry is compared, the deepest included
        for (int i = 0; i < shadow_fill; i++) begin
          if (!hit && shadow_stack[i] == value) begin
            hit              = 1'b1;
            r.ok             = 1'b1;
            r.found_position = POS_W'(i);
          end
        end
      end
      default: begin
        if (pos < shadow_fill) begin
          r.ok         = 1'b1;
          r.read_value = shadow_stack[pos];
        end
      end
    endcase
    r.count = COUNT_W'(shadow_fill);
    return r;
  endfunction

  task automatic check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, name, exp_v, act_v);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DEPTH; i++) shadow_stack[i] = '0;
      shadow_fill = 0;
      pending_results.delete();
    end else begin
      // output first: an input taken at this edge has its result later
      if (out_valid && out_ready) begin
        seen++;
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result: expected none, got ok=%0b count=%0d",
                   $time, out_ok, out_count);
          fails++;
        end else begin
          oldest = pending_results.pop_front();
          check_field("ok", oldest.ok, out_ok);
          check_field("read_value", oldest.read_value, out_read_value);
          check_field("found_position", oldest.found_position, out_found_position);
          check_field("count", oldest.count, out_count);
        end
      end
      if (in_valid && in_ready)
        pending_results.push_back(apply_stack_op(op_kind_t'(in_kind), in_value, in_position));
    end
    fail_count   <= fails;
    results_seen <= seen;
  end

endmodule : slstk_result_checker

FILE: sim/tb_searchable_lifo_stack_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_searchable_lifo_stack_top
// Stimulus and verdict for the searchable LIFO stack. A directed run covers
// empty and full limits, extreme values and deepest-entry search; random
// operations follow with shifting push bias so the stack swings between
// empty and full. Both sides idle at random; once the receiver holds off
// long enough for the block to stall its input.
// ---------------------------------------------------------------------------
module tb_searchable_lifo_stack_top;
  import slstk_pkg::*;

  localparam int RANDOM_OPS  = 650;
  localparam int CYCLE_LIMIT = 200000;
  // no idling on either side while this many transfers have gone in
  localparam int CALM_FIRST  = 300;
  localparam int CALM_LAST   = 420;
  // long receiver hold-off, started once this many transfers have gone in
  localparam int HOLD_AT     = 120;
  localparam int HOLD_CYCLES = 60;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic [1:0]               in_kind = OP_PUSH;
  logic signed [DATA_W-1:0] in_value = '0;
  logic [POS_W-1:0]         in_position = '0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic                     out_ok;
  logic signed [DATA_W-1:0] out_read_value;
  logic [POS_W-1:0]         out_found_position;
  logic [COUNT_W-1:0]       out_count;

  int fail_count;
  int results_seen;
  int sent_count = 0;
  int cycles = 0;

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  searchable_lifo_stack_top u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_kind            (in_kind),
    .in_value           (in_value),
    .in_position        (in_position),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_ok             (out_ok),
    .out_read_value     (out_read_value),
    .out_found_position (out_found_position),
    .out_count          (out_count)
  );

  slstk_result_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_kind            (in_kind),
    .in_value           (in_value),
    .in_position        (in_position),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_ok             (out_ok),
    .out_read_value     (out_read_value),
    .out_found_position (out_found_position),
    .out_count          (out_count),
    .fail_count         (fail_count),
    .results_seen       (results_seen)
  );

  // Stretch of the run in which neither side idles.
  function automatic bit calm_window();
    return sent_count >= CALM_FIRST && sent_count < CALM_LAST;
  endfunction

  // Offers one operation and waits for its transfer. Idle cycles go before
  // the item; valid is never lowered once raised until the transfer.
  task automatic send_op(input op_kind_t kind, input logic signed [DATA_W-1:0] value,
                         input logic [POS_W-1:0] pos);
    while (!calm_window() && $urandom_range(99) < 31) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_kind     <= kind;
    in_value    <= value;
    in_position <= pos;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_count++;
  endtask

  // Values lean towards the extremes and a small pool, so searches hit often
  // and duplicates appear; the rest are fully random 32-bit words.
  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(9))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7FFF_FFFF;
      2:       return '0;
      3:       return -32'sd1;
      4, 5, 6: return DATA_W'($urandom_range(7));
      default: return $urandom;
    endcase
  endfunction

  // Mostly positions in 0..DEPTH, sometimes anywhere in 0..255.
  function automatic logic [POS_W-1:0] pick_position();
    if ($urandom_range(99) < 75) return POS_W'($urandom_range(DEPTH));
    return POS_W'($urandom_range(255));
  endfunction

  // Receiver: random idling, a calm stretch, and one long hold-off counted
  // here so the block fills its result queue and drops in_ready.
  initial begin
    int  hold_left;
    bit  hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (!hold_done && sent_count >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_ready <= 1'b0;
      end else if (calm_window()) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= 31);
      end
      @(posedge clk);
    end
  end

  // Run limit
  initial begin
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    int       push_bias;
    int       pick;
    op_kind_t kind;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed part ----
    // empty stack: pop refused, search misses, read out of range
    send_op(OP_POP, 32'sh1234_5678, 8'd0);
    send_op(OP_SEARCH, '0, 8'd0);
    send_op(OP_READ, '0, 8'd0);
    // extremes of the value field; position ignored on push
    send_op(OP_PUSH, 32'sh8000_0000, 8'd0);
    send_op(OP_PUSH, 32'sh7FFF_FFFF, 8'd255);
    send_op(OP_PUSH, '0, 8'd0);
    send_op(OP_PUSH, -32'sd1, 8'd255);
    send_op(OP_SEARCH, 32'sh8000_0000, 8'd255);
    send_op(OP_SEARCH, -32'sd1, 8'd0);
    send_op(OP_SEARCH, 32'sd12345, 8'd0);
    send_op(OP_READ, 32'sh7FFF_FFFF, 8'd0);
    send_op(OP_READ, '0, 8'd3);
    // read exactly at the fill, and at the largest position
    send_op(OP_READ, '0, 8'd4);
    send_op(OP_READ, '0, 8'd255);
    // fill up, with a duplicate value so search must give the top-most copy
    send_op(OP_PUSH, 32'sd5, 8'd0);
    send_op(OP_PUSH, 32'sd5, 8'd0);
    send_op(OP_PUSH, 32'sd6, 8'd0);
    send_op(OP_PUSH, 32'sd7, 8'd0);
    // push when full: refused
    send_op(OP_PUSH, 32'sd9, 8'd0);
    send_op(OP_SEARCH, 32'sd5, 8'd0);
    // deepest entry must be searchable and readable
    send_op(OP_SEARCH, 32'sh8000_0000, 8'd0);
    send_op(OP_READ, '0, 8'(DEPTH - 1));
    // drain to empty, then one pop too many
    repeat (DEPTH + 1) send_op(OP_POP, -32'sd1, 8'd255);

    // ---- random part ----
    // push bias is drawn anew every 40 items so the fill sweeps empty to full
    push_bias = 50;
    for (int n = 0; n < RANDOM_OPS; n++) begin
      if (n % 40 == 0) begin
        case ($urandom_range(2))
          0:       push_bias = 15;
          1:       push_bias = 50;
          default: push_bias = 85;
        endcase
      end
      if ($urandom_range(99) < push_bias) begin
        kind = OP_PUSH;
      end else begin
        pick = $urandom_range(2);
        kind = (pick == 0) ? OP_POP : (pick == 1) ? OP_SEARCH : OP_READ;
      end
      send_op(kind, pick_value(), pick_position());
    end
    in_valid <= 1'b0;

    // wait for every result, then a short drain for stray transfers
    while (results_seen < sent_count) @(posedge clk);
    repeat (4) @(posedge clk);

    if (fail_count == 0 && results_seen == sent_count) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule : tb_searchable_lifo_stack_top

FILE: files.f
rtl/slstk_pkg.sv
rtl/slstk_cell.sv
rtl/slstk_out_buf.sv
rtl/searchable_lifo_stack_top.sv
sim/slstk_result_checker.sv
sim/tb_searchable_lifo_stack_top.sv
